>>> src/hlr_pkg.sv
// Shared types and constants for the hue and lightness to RGB pixel pipeline.
`default_nettype none

package hlr_pkg;

	localparam int unsigned LATENCY = 8;

	localparam logic [11:0] RED_OFFSET   = 12'd1024;
	localparam logic [11:0] GREEN_OFFSET = 12'd3306;
	localparam logic [11:0] BLUE_OFFSET  = 12'd2328;

	localparam logic [12:0] RED_GAIN   = 13'd6836;
	localparam logic [12:0] GREEN_GAIN = 13'd2591;
	localparam logic [12:0] BLUE_GAIN  = 13'd7470;

	localparam logic [14:0] ONE_Q14   = 15'd16384;
	localparam logic [13:0] HALF_Q14  = 14'd8192;
	localparam logic [14:0] V_MAX     = 15'd32767;
	localparam logic [13:0] MAP_MUL   = 14'd15125;
	localparam logic [13:0] MAP_ROUND = 14'd8192;
	localparam logic [10:0] MAP_ADD   = 11'd1296;

	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

	typedef struct packed {
		logic [13:0] l;
		logic [14:0] c;
	} lc_t;

endpackage

`default_nettype wire

>>> src/hue_lightness_to_rgb.sv
// Top level of the hue and lightness to RGB pixel pipeline.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------
//  command  | hue_phase, lightness           | start, taken when busy is low
//  result   | red, green, blue               | pixel_valid, one cycle strobe
//
// A pixel is taken in every cycle; its result leaves through the registered stages of each
// channel in order: sine address, sine table read, gain multiply, chroma multiply, lightness
// add, tone map, power index and power table read.
// Reset clears the valid bits only; the tables are constants and need no fill.
// The pipeline never stops, so busy stays low and results cannot be held off.
`default_nettype none

module hue_lightness_to_rgb
	import hlr_pkg::*;
#(
	parameter int unsigned SINE_TABLE_DEPTH  = 1024,
	parameter int unsigned POWER_TABLE_DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [11:0] hue_phase,
	input  wire logic [9:0]  lightness,
	output logic             pixel_valid,
	output logic      [7:0]  red,
	output logic      [7:0]  green,
	output logic      [7:0]  blue
);

	logic [13:0]        l_in;
	logic [13:0]        l_dev;
	lc_t                lc;
	logic [LATENCY-1:0] vld_q;

	assign busy = 1'b0;

	always_comb begin
		l_in = {lightness, 4'b0000};
		if (l_in >= HALF_Q14) begin
			l_dev = l_in - HALF_Q14;
		end else begin
			l_dev = HALF_Q14 - l_in;
		end
		lc.l = l_in;
		lc.c = ONE_Q14 - {l_dev, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], start & ~busy};
		end
	end

	assign pixel_valid = vld_q[LATENCY-1];

	hlr_channel #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.POWER_TABLE_DEPTH(POWER_TABLE_DEPTH),
		.OFFSET(RED_OFFSET),
		.GAIN(RED_GAIN)
	) u_red (
		.clk(clk),
		.hue_phase(hue_phase),
		.lc(lc),
		.level(red)
	);

	hlr_channel #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.POWER_TABLE_DEPTH(POWER_TABLE_DEPTH),
		.OFFSET(GREEN_OFFSET),
		.GAIN(GREEN_GAIN)
	) u_green (
		.clk(clk),
		.hue_phase(hue_phase),
		.lc(lc),
		.level(green)
	);

	hlr_channel #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.POWER_TABLE_DEPTH(POWER_TABLE_DEPTH),
		.OFFSET(BLUE_OFFSET),
		.GAIN(BLUE_GAIN)
	) u_blue (
		.clk(clk),
		.hue_phase(hue_phase),
		.lc(lc),
		.level(blue)
	);

endmodule

`default_nettype wire

>>> src/hlr_sine_rom.sv
// Quarter-wave Q0.15 sine table with a registered read port.
`default_nettype none

module hlr_sine_rom
	import hlr_pkg::*;
#(
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic [AW-1:0] addr,
	output logic      [14:0]   data_s2
);

	typedef logic [14:0] tbl_t [DEPTH+1];

	function automatic tbl_t build_table();
		tbl_t        tbl;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [64:0] sum;
		logic [63:0] q;
		for (int i = 0; i <= DEPTH; i++) begin
			x = (64'(i) * PI_HALF_Q30) / 64'(DEPTH);
			x2 = (x * x) >> 30;
			term = x;
			sum = 65'(x);
			term = ((term * x2) >> 30) / 64'd6;
			sum = sum - 65'(term);
			term = ((term * x2) >> 30) / 64'd20;
			sum = sum + 65'(term);
			term = ((term * x2) >> 30) / 64'd42;
			sum = sum - 65'(term);
			term = ((term * x2) >> 30) / 64'd72;
			sum = sum + 65'(term);
			term = ((term * x2) >> 30) / 64'd110;
			sum = sum - 65'(term);
			term = ((term * x2) >> 30) / 64'd156;
			sum = sum + 65'(term);
			if (sum < 0) begin
				sum = '0;
			end
			q = (64'(sum) + 64'd16384) >> 15;
			if (q > 64'd32767) begin
				q = 64'd32767;
			end
			tbl[i] = q[14:0];
		end
		return tbl;
	endfunction

	localparam tbl_t SINE_TBL = build_table();

	always_ff @(posedge clk) begin
		data_s2 <= SINE_TBL[addr];
	end

endmodule

`default_nettype wire

>>> src/hlr_pow_rom.sv
// Table of floor(255 * t^1.25) with a registered read port.
`default_nettype none

module hlr_pow_rom #(
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic [AW-1:0] addr,
	output logic      [7:0]    data_s8
);

	typedef logic [7:0] tbl_t [DEPTH];

	function automatic logic [63:0] floor_sqrt(input logic [63:0] a_in);
		logic [63:0] a;
		logic [63:0] res;
		logic [63:0] bitv;
		a = a_in;
		res = '0;
		bitv = 64'd1 << 62;
		for (int n = 0; n < 32; n++) begin
			if (a >= res + bitv) begin
				a = a - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic tbl_t build_table();
		tbl_t        tbl;
		logic [63:0] t;
		logic [63:0] r2;
		logic [63:0] r4;
		logic [63:0] p;
		logic [63:0] e;
		for (int i = 0; i < DEPTH; i++) begin
			t = (64'(i) << 30) / 64'(DEPTH - 1);
			r2 = floor_sqrt(t << 30);
			r4 = floor_sqrt(r2 << 30);
			p = (t * r4) >> 30;
			e = (p * 64'd255) >> 30;
			if (e > 64'd255) begin
				e = 64'd255;
			end
			tbl[i] = e[7:0];
		end
		return tbl;
	endfunction

	localparam tbl_t POW_TBL = build_table();

	always_ff @(posedge clk) begin
		data_s8 <= POW_TBL[addr];
	end

endmodule

`default_nettype wire

>>> src/hlr_channel.sv
// One colour channel: sine lookup, chroma scaling, tone map and power lookup.
`default_nettype none

module hlr_channel
	import hlr_pkg::*;
#(
	parameter int unsigned SINE_TABLE_DEPTH  = 1024,
	parameter int unsigned POWER_TABLE_DEPTH = 1024,
	parameter logic [11:0] OFFSET            = 12'd1024,
	parameter logic [12:0] GAIN              = 13'd6836
) (
	input  wire logic        clk,
	input  wire logic [11:0] hue_phase,
	input  wire lc_t         lc,
	output logic      [7:0]  level
);

	localparam int unsigned SW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int unsigned PW = $clog2(POWER_TABLE_DEPTH);
	localparam logic [26:0] PMAX = 27'(POWER_TABLE_DEPTH - 1);

	logic [11:0] phase;
	logic [10:0] quarter;
	logic [23:0] idx_full;

	logic [SW-1:0] idx_s1;
	logic          neg_s1;
	lc_t           lc_s1;

	logic [14:0] sin_s2;
	logic        neg_s2;
	lc_t         lc_s2;

	logic [27:0] sg_s3;
	logic        neg_s3;
	lc_t         lc_s3;

	logic [42:0] full;
	logic [13:0] mag_s4;
	logic        neg_s4;
	logic [13:0] l_s4;

	logic signed [15:0] v_sum;
	logic [14:0]        v_s5;

	logic [28:0] map_prod;
	logic [15:0] m_raw;
	logic [14:0] m_s6;

	logic [26:0]   j_prod;
	logic [26:0]   j_raw;
	logic [PW-1:0] j_s7;

	always_comb begin
		phase = hue_phase + OFFSET;
		quarter = {1'b0, phase[9:0]};
		if (phase[10]) begin
			quarter = 11'd1024 - quarter;
		end
		idx_full = (24'(quarter) * 24'(SINE_TABLE_DEPTH)) >> 10;
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_full[SW-1:0];
		neg_s1 <= phase[11];
		lc_s1 <= lc;
	end

	hlr_sine_rom #(
		.DEPTH(SINE_TABLE_DEPTH)
	) u_sine (
		.clk(clk),
		.addr(idx_s1),
		.data_s2(sin_s2)
	);

	always_ff @(posedge clk) begin
		neg_s2 <= neg_s1;
		lc_s2 <= lc_s1;
		sg_s3 <= 28'(sin_s2) * 28'(GAIN);
		neg_s3 <= neg_s2;
		lc_s3 <= lc_s2;
	end

	assign full = 43'(sg_s3) * 43'(lc_s3.c);

	always_ff @(posedge clk) begin
		mag_s4 <= full[42:29];
		neg_s4 <= neg_s3;
		l_s4 <= lc_s3.l;
	end

	always_comb begin
		if (neg_s4) begin
			v_sum = signed'({2'b00, l_s4}) - signed'({2'b00, mag_s4});
		end else begin
			v_sum = signed'({2'b00, l_s4}) + signed'({2'b00, mag_s4});
		end
	end

	always_ff @(posedge clk) begin
		if (v_sum < 0) begin
			v_s5 <= '0;
		end else if (v_sum > signed'({1'b0, V_MAX})) begin
			v_s5 <= V_MAX;
		end else begin
			v_s5 <= v_sum[14:0];
		end
	end

	always_comb begin
		map_prod = 29'(v_s5) * 29'(MAP_MUL);
		m_raw = 16'((map_prod + 29'(MAP_ROUND)) >> 14) + 16'(MAP_ADD);
	end

	always_ff @(posedge clk) begin
		if (m_raw > 16'(ONE_Q14)) begin
			m_s6 <= ONE_Q14;
		end else begin
			m_s6 <= m_raw[14:0];
		end
	end

	always_comb begin
		j_prod = 27'(m_s6) * PMAX;
		j_raw = (j_prod + 27'(MAP_ROUND)) >> 14;
	end

	always_ff @(posedge clk) begin
		if (j_raw > PMAX) begin
			j_s7 <= PMAX[PW-1:0];
		end else begin
			j_s7 <= j_raw[PW-1:0];
		end
	end

	hlr_pow_rom #(
		.DEPTH(POWER_TABLE_DEPTH)
	) u_pow (
		.clk(clk),
		.addr(j_s7),
		.data_s8(level)
	);

endmodule

`default_nettype wire

>>> src/hlr_checker.sv
// Port checks for the pixel pipeline and their binding to the top level.
`default_nettype none

module hlr_checker
	import hlr_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [9:0]  lightness,
	input wire logic        pixel_valid,
	input wire logic [7:0]  red,
	input wire logic [7:0]  green,
	input wire logic [7:0]  blue
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy was raised");

	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY pixel_valid)
		else $error("accepted word gave no pixel");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LATENCY !pixel_valid)
		else $error("pixel strobe without a command word");

	a_black_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && lightness == 10'd0) |->
		##LATENCY (red == green && green == blue))
		else $error("zero lightness gave a coloured pixel");

endmodule

bind hue_lightness_to_rgb hlr_checker u_hlr_checker (.*);

`default_nettype wire

>>> verif/hue_lightness_to_rgb_checker.sv
// Checker for the hue and lightness to RGB pipeline: predicts each pixel and compares it.
`timescale 1ns / 1ps

module hue_lightness_to_rgb_checker #(
	parameter int unsigned SINE_DEPTH  = 1024,
	parameter int unsigned POWER_DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [11:0] hue_phase,
	input  wire logic [9:0]  lightness,
	input  wire logic        pixel_valid,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	output int unsigned      fail_count,
	output int unsigned      pending
);

	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
	localparam logic [11:0] RED_SHIFT   = 12'd1024;
	localparam logic [11:0] GREEN_SHIFT = 12'd3306;
	localparam logic [11:0] BLUE_SHIFT  = 12'd2328;
	localparam longint RED_GAIN_Q14   = 6836;
	localparam longint GREEN_GAIN_Q14 = 2591;
	localparam longint BLUE_GAIN_Q14  = 7470;
	localparam int unsigned MAX_PRINTED = 200;

	typedef struct packed {
		logic [11:0] hue;
		logic [9:0]  light;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} pixel_word_t;

	int unsigned sine_rom [0:SINE_DEPTH];
	int unsigned power_rom [0:POWER_DEPTH-1];
	pixel_word_t expected_pixels [$];
	pixel_word_t oldest;

	function automatic longint unsigned isqrt(input longint unsigned a);
		longint unsigned root;
		longint unsigned bitpos;
		root = 0;
		bitpos = 64'd1 << 62;
		while (bitpos > a)
			bitpos = bitpos >> 2;
		while (bitpos != 0) begin
			if (a >= root + bitpos) begin
				a = a - (root + bitpos);
				root = (root >> 1) + bitpos;
			end else begin
				root = root >> 1;
			end
			bitpos = bitpos >> 2;
		end
		return root;
	endfunction

	task automatic build_tables();
		longint unsigned idx, x, x2, term, q, t, r2, r4, p, e;
		longint sum;
		for (idx = 0; idx <= SINE_DEPTH; idx++) begin
			x = idx * QUARTER_TURN_Q30 / SINE_DEPTH;
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			for (int k = 1; k <= 6; k++) begin
				term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
				if (k % 2 == 1)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			q = (longint'(sum) + 64'd16384) >> 15;
			if (q > 32767)
				q = 32767;
			sine_rom[idx] = 32'(q);
		end
		for (idx = 0; idx < POWER_DEPTH; idx++) begin
			t = (idx << 30) / (POWER_DEPTH - 1);
			r2 = isqrt(t << 30);
			r4 = isqrt(r2 << 30);
			p = (t * r4) >> 30;
			e = (p * 255) >> 30;
			if (e > 255)
				e = 255;
			power_rom[idx] = 32'(e);
		end
	endtask

	function automatic longint sine_q15(input logic [11:0] phase);
		int unsigned quadrant, frac, idx;
		longint s;
		quadrant = 32'(phase[11:10]);
		frac = 32'(phase[9:0]);
		if (quadrant % 2 == 1)
			frac = 1024 - frac;
		idx = (frac * SINE_DEPTH) >> 10;
		if (idx > SINE_DEPTH)
			idx = SINE_DEPTH;
		s = longint'(sine_rom[idx]);
		return (quadrant >= 2) ? -s : s;
	endfunction

	function automatic logic [7:0] channel_level(input logic [11:0] phase, input longint gain,
			input longint l, input longint c);
		longint prod, mag, v, m, j;
		prod = sine_q15(phase) * gain * c;
		mag = ((prod < 0) ? -prod : prod) >>> 29;
		v = (prod < 0) ? l - mag : l + mag;
		if (v < 0)
			v = 0;
		if (v > 32767)
			v = 32767;
		m = ((v * 15125 + 8192) >>> 14) + 1296;
		if (m > 16384)
			m = 16384;
		j = (m * (POWER_DEPTH - 1) + 8192) >>> 14;
		if (j > POWER_DEPTH - 1)
			j = POWER_DEPTH - 1;
		return power_rom[j][7:0];
	endfunction

	function automatic pixel_word_t predict_pixel(input logic [11:0] hue, input logic [9:0] light);
		pixel_word_t px;
		longint l, d, c;
		l = longint'(light) << 4;
		d = l - 8192;
		if (d < 0)
			d = -d;
		c = 16384 - 2 * d;
		if (c < 0)
			c = 0;
		px.hue = hue;
		px.light = light;
		px.red = channel_level(hue + RED_SHIFT, RED_GAIN_Q14, l, c);
		px.green = channel_level(hue + GREEN_SHIFT, GREEN_GAIN_Q14, l, c);
		px.blue = channel_level(hue + BLUE_SHIFT, BLUE_GAIN_Q14, l, c);
		return px;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_count < MAX_PRINTED)
			$display("%0t mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_channel(input string name, input logic [7:0] got, input logic [7:0] want,
			input pixel_word_t px);
		if (got !== want)
			report_mismatch($sformatf("%s hue %0d lightness %0d: got %0d, expected %0d",
				name, px.hue, px.light, got, want));
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		build_tables();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_valid) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("pixel %0d/%0d/%0d with no word outstanding",
						red, green, blue));
				end else begin
					oldest = expected_pixels.pop_front();
					check_channel("red", red, oldest.red, oldest);
					check_channel("green", green, oldest.green, oldest);
					check_channel("blue", blue, oldest.blue, oldest);
				end
			end
			if (start && !busy)
				expected_pixels.push_back(predict_pixel(hue_phase, lightness));
			pending <= expected_pixels.size();
		end
	end

endmodule

>>> verif/hue_lightness_to_rgb_tb.sv
// Testbench top for the hue and lightness to RGB pipeline: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module hue_lightness_to_rgb_tb;

	import hlr_pkg::*;

	localparam int unsigned SINE_DEPTH  = 1024;
	localparam int unsigned POWER_DEPTH = 1024;
	localparam int unsigned RANDOM_WORDS = 500;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DIRECTED_WORDS = 24;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [11:0] hue_phase;
	logic [9:0]  lightness;
	logic        pixel_valid;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycles;
	int unsigned burst_left;

	int unsigned directed_hue [0:DIRECTED_WORDS-1] = '{
		0, 0, 4095, 4095, 0, 1024, 2048, 3072, 0, 0, 1023, 1025,
		2047, 2049, 3071, 3073, 0, 3072, 2048, 2048, 1000, 1234, 2906, 3720};
	int unsigned directed_light [0:DIRECTED_WORDS-1] = '{
		0, 1023, 1023, 0, 512, 512, 512, 512, 511, 513, 700, 300,
		900, 100, 960, 40, 1000, 1000, 1, 2, 3, 1022, 1020, 4};

	hue_lightness_to_rgb #(
		.SINE_TABLE_DEPTH(SINE_DEPTH),
		.POWER_TABLE_DEPTH(POWER_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.hue_phase(hue_phase),
		.lightness(lightness),
		.pixel_valid(pixel_valid),
		.red(red),
		.green(green),
		.blue(blue)
	);

	hue_lightness_to_rgb_checker #(
		.SINE_DEPTH(SINE_DEPTH),
		.POWER_DEPTH(POWER_DEPTH)
	) checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.hue_phase(hue_phase),
		.lightness(lightness),
		.pixel_valid(pixel_valid),
		.red(red),
		.green(green),
		.blue(blue),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic hold_off(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_word(input logic [11:0] hue, input logic [9:0] light);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0)
				hold_off(gap);
			burst_left = $urandom_range(1, 40);
		end
		start <= 1'b1;
		hue_phase <= hue;
		lightness <= light;
		do
			@(posedge clk);
		while (busy);
		burst_left--;
	endtask

	task automatic drain_pixels();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin
		logic [11:0] hue;
		logic [9:0] light;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		hue_phase = '0;
		lightness = '0;
		cycles = 0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_WORDS; i++)
			send_word(12'(directed_hue[i]), 10'(directed_light[i]));
		drain_pixels();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 2)
				drain_pixels();
			case ($urandom_range(0, 9))
				0: begin
					hue = 12'($urandom);
					light = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 3))
						: 10'($urandom_range(1020, 1023));
				end
				1: begin
					hue = 12'($urandom);
					light = 10'($urandom_range(509, 515));
				end
				2: begin
					hue = 12'(($urandom_range(0, 3) << 10) + $urandom_range(0, 2) - 1);
					light = 10'($urandom);
				end
				default: begin
					hue = 12'($urandom);
					light = 10'($urandom);
				end
			endcase
			send_word(hue, light);
		end

		drain_pixels();
		repeat (LATENCY + 4) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
